// ----- rtl/core/awr_pkg.sv -----
package awr_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 128;
	localparam int MAX_CHANNELS = 8;
	localparam int STORE_SIZE   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_SIZE);
	localparam int DIV_W        = 16;

	localparam logic [7:0] GRAY_FULL = 8'hFF;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;
	localparam logic [1:0] REG_SPC      = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [8:0] clamp_width(input logic [8:0] v);
		if (v == 9'd0) return 9'd1;
		if (v > 9'(MAX_WIDTH)) return 9'(MAX_WIDTH);
		return v;
	endfunction

	function automatic logic [7:0] clamp_height(input logic [7:0] v);
		if (v == 8'd0) return 8'd1;
		if (v > 8'(MAX_HEIGHT)) return 8'(MAX_HEIGHT);
		return v;
	endfunction

	function automatic logic [3:0] clamp_chan(input logic [3:0] v);
		if (v == 4'd0) return 4'd1;
		if (v > 4'(MAX_CHANNELS)) return 4'(MAX_CHANNELS);
		return v;
	endfunction

endpackage

// ----- rtl/core/audio_waveform_rasterizer.sv -----
// channel   direction  handshake              payload
// s         in         s_tvalid/s_tready      s_tdata: sample_value, pixel_address; s_tuser: op
// m         out        m_tvalid/m_tready      m_tdata: pixel_value
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// Reset and every start item run a clearing pass over all 32768 bitmap entries.
// A start first runs a division in the shared divider before that pass.
// A sample runs two passes through the 16-step divider, then a read and a write per
// line pixel on the bitmap's separate read and write ports.
// A read goes through S_RD1 and S_RD2; s_tready stays low while any item is at work.
module audio_waveform_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_value[15:0], pixel_address[30:16]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pixel_value[7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import awr_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CLEAR = 12'b000000000010,
		S_DGRAY = 12'b000000000100,
		S_MUL   = 12'b000000001000,
		S_DLEN  = 12'b000000010000,
		S_DCEN  = 12'b000000100000,
		S_BASE  = 12'b000001000000,
		S_PIXRD = 12'b000010000000,
		S_PIXWR = 12'b000100000000,
		S_ADV   = 12'b001000000000,
		S_RD1   = 12'b010000000000,
		S_RD2   = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [8:0]  width_q;
	logic [7:0]  height_q;
	logic [3:0]  chan_q;
	logic [15:0] spc_q;

	logic [2:0]  channel_q;
	logic [15:0] column_q;
	logic [15:0] frames_q;
	logic [7:0]  gray_q;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [15:0] mag_q;
	logic        neg_q;
	logic [2:0]  j_q;
	logic [23:0] prod_q;
	logic [11:0] cen_q;
	logic [7:0]  len_q;
	logic [7:0]  center_q;
	logic [7:0]  k_q;
	logic [8:0]  row_q;
	logic        rd_ok_q;
	logic        div_go_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;

	logic [8:0]  w_eff;
	logic [7:0]  h_eff;
	logic [3:0]  c_eff;
	logic [15:0] spc_eff;
	logic        accept;
	logic [1:0]  in_op;
	logic [15:0] in_sample;
	logic [14:0] in_addr;
	logic [3:0]  j_next;
	logic [7:0]  top;
	logic [16:0] base;
	logic        is_end;
	logic        out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [7:0]        mem_rdata;

	assign w_eff   = clamp_width(width_q);
	assign h_eff   = clamp_height(height_q);
	assign c_eff   = clamp_chan(chan_q);
	assign spc_eff = (spc_q == 16'd0) ? 16'd1 : spc_q;

	assign in_op     = s_tuser;
	assign in_sample = s_tdata[15:0];
	assign in_addr   = s_tdata[30:16];

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign j_next = {1'b0, j_q} + 4'd1;
	assign top    = neg_q ? center_q : (center_q - len_q);
	assign base   = 17'(top) * 17'(w_eff) + 17'(column_q[8:0]);
	assign is_end = neg_q ? (k_q == 8'd0) : (k_q == len_q);

	always_comb begin
		div_req.start    = div_go_q;
		div_req.dividend = '0;
		div_req.divisor  = 16'd1;
		unique case (state_q)
			S_DGRAY: begin
				div_req.dividend = 16'(GRAY_FULL);
				div_req.divisor  = spc_eff;
			end
			S_DLEN: begin
				div_req.dividend = 16'(prod_q[23:16]);
				div_req.divisor  = 16'(c_eff);
			end
			S_DCEN: begin
				div_req.dividend = 16'(cen_q);
				div_req.divisor  = 16'({c_eff, 1'b0});
			end
			default: ;
		endcase
	end

	awr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = is_end ? GRAY_FULL : (mem_rdata + gray_q);
		mem_re    = 1'b0;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_PIXWR) begin
			mem_we = 1'b1;
		end
		if (state_q == S_PIXRD || state_q == S_RD1) mem_re = 1'b1;
	end

	awr_bitmap u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'(MAX_WIDTH);
			height_q <= 8'(MAX_HEIGHT);
			chan_q   <= 4'd2;
			spc_q    <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data[8:0];
				REG_HEIGHT:   height_q <= cfg_data[7:0];
				REG_CHANNELS: chan_q   <= cfg_data[3:0];
				REG_SPC:      spc_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			channel_q  <= '0;
			column_q   <= '0;
			frames_q   <= '0;
			gray_q     <= GRAY_FULL;
			div_go_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// pulse the divider on a start item, after the multiply and after the length
			div_go_q <= (accept && in_op == OP_START) || (state_q == S_MUL) ||
				(state_q == S_DLEN && div_rsp.done);
			if (state_q == S_RD2 && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_START: begin
								channel_q <= '0;
								column_q  <= '0;
								frames_q  <= '0;
								state_q   <= S_DGRAY;
							end
							OP_DRAW: state_q <= S_MUL;
							OP_READ: state_q <= S_RD1;
							default: ;
						endcase
					end
				end
				S_DGRAY: begin
					if (div_rsp.done) begin
						gray_q  <= div_rsp.quot[7:0];
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_SIZE - 1)) state_q <= S_IDLE;
				end
				S_MUL: state_q <= S_DLEN;
				S_DLEN: begin
					if (div_rsp.done) state_q <= S_DCEN;
				end
				S_DCEN: begin
					if (div_rsp.done) state_q <= S_BASE;
				end
				S_BASE: begin
					// drop the whole line when its column lies right of the bitmap
					if (column_q >= 16'(w_eff)) state_q <= S_ADV;
					else state_q <= S_PIXRD;
				end
				S_PIXRD: begin
					if (row_q >= 9'(h_eff)) state_q <= S_ADV;
					else state_q <= S_PIXWR;
				end
				S_PIXWR: begin
					if (k_q == len_q) state_q <= S_ADV;
					else state_q <= S_PIXRD;
				end
				S_ADV: begin
					if (j_next >= c_eff) begin
						channel_q <= '0;
						if (frames_q + 16'd1 >= spc_eff) begin
							frames_q <= '0;
							if (column_q != 16'hFFFF) column_q <= column_q + 16'd1;
						end else begin
							frames_q <= frames_q + 16'd1;
						end
					end else begin
						channel_q <= j_next[2:0];
					end
					state_q <= S_IDLE;
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= in_sample[15];
			mag_q   <= in_sample[15] ? (16'd0 - in_sample) : in_sample;
			j_q     <= ({1'b0, channel_q} >= c_eff) ? 3'd0 : channel_q;
			addr_q  <= in_addr;
			rd_ok_q <= 17'(in_addr) < 17'(w_eff) * 17'(h_eff);
		end
		if (state_q == S_MUL) begin
			prod_q <= 24'(h_eff) * 24'(mag_q);
			cen_q  <= 12'(h_eff) * 12'({j_q, 1'b1});
		end
		if (state_q == S_DLEN && div_rsp.done) len_q <= div_rsp.quot[7:0];
		if (state_q == S_DCEN && div_rsp.done) center_q <= div_rsp.quot[7:0];
		if (state_q == S_BASE) begin
			addr_q <= base[ADDR_W-1:0];
			row_q  <= {1'b0, top};
			k_q    <= '0;
		end
		if (state_q == S_PIXWR) begin
			addr_q <= addr_q + ADDR_W'(w_eff);
			row_q  <= row_q + 9'd1;
			k_q    <= k_q + 8'd1;
		end
		if (state_q == S_RD2 && out_free) m_tdata_q <= rd_ok_q ? mem_rdata : 8'd0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE && !div_go_q)
		else $error("ready outside idle");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DGRAY || state_q == S_DLEN || state_q == S_DCEN))
		else $error("divider result with no consumer");

	a_pix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PIXWR |-> k_q <= len_q && row_q < 9'(h_eff))
		else $error("line pixel out of range");

	a_read_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD2 && out_free |=> m_tvalid)
		else $error("read result lost");

endmodule

// ----- rtl/core/awr_div.sv -----
module awr_div (
	input  logic             clk,
	input  logic             arst_n,
	input  awr_pkg::div_req_t req,
	output awr_pkg::div_rsp_t rsp
);
	import awr_pkg::*;

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[DIV_W-1:0], dvd_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- rtl/core/awr_bitmap.sv -----
module awr_bitmap (
	input  logic                      clk,
	input  logic                      we,
	input  logic [awr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [awr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);
	import awr_pkg::*;

	logic [7:0] mem [STORE_SIZE];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
